// ===== design/i2cf_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cf_pkg
// Shared types, constants and the frame builder for the display byte framer.
// ----------------------------------------------------------------------------
package i2cf_pkg;

  localparam int FRAME_LEN = 29;

  localparam logic [7:0] CTRL_COMMAND = 8'h00;
  localparam logic [7:0] CTRL_DATA    = 8'h40;

  localparam logic [7:0] RST_SLAVE_ADDR = 8'h78;
  localparam logic [7:0] RST_BIT_HOLD   = 8'd2;
  localparam logic [7:0] RST_FRAME_HOLD = 8'd5;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_kind_t;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDR = 2'd0,
    REG_BIT_HOLD   = 2'd1,
    REG_FRAME_HOLD = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       is_data;
  } in_word_t;

  typedef struct packed {
    sym_kind_t  symbol_kind;
    logic       bit_value;
    logic [7:0] hold_units;
    logic       last_symbol;
  } out_word_t;

  typedef struct packed {
    sym_kind_t kind;
    logic      bit_value;
  } sym_t;

  typedef sym_t [FRAME_LEN-1:0] frame_t;

  typedef struct packed {
    logic [7:0] slave_addr;
    logic [7:0] bit_hold;
    logic [7:0] frame_hold;
  } cfg_t;

  function automatic logic [7:0] hold_of(logic [7:0] r);
    return (r == 8'd0) ? 8'd1 : r;
  endfunction

  function automatic frame_t build_frame(logic [7:0] addr, logic [7:0] pay,
                                         logic is_data);
    frame_t     f;
    logic [7:0] ctrl;
    ctrl = is_data ? CTRL_DATA : CTRL_COMMAND;
    f[0] = '{kind: SYM_START, bit_value: 1'b0};
    for (int i = 0; i < 8; i++) begin
      f[1 + i]  = '{kind: SYM_BIT, bit_value: addr[7 - i]};
      f[10 + i] = '{kind: SYM_BIT, bit_value: ctrl[7 - i]};
      f[19 + i] = '{kind: SYM_BIT, bit_value: pay[7 - i]};
    end
    f[9]  = '{kind: SYM_ACK, bit_value: 1'b0};
    f[18] = '{kind: SYM_ACK, bit_value: 1'b0};
    f[27] = '{kind: SYM_ACK, bit_value: 1'b0};
    f[28] = '{kind: SYM_STOP, bit_value: 1'b0};
    return f;
  endfunction

endpackage

// ===== design/i2cf_cell.sv =====
// ----------------------------------------------------------------------------
// i2cf_cell
// One symbol slot of the frame chain: loads in parallel, shifts toward head.
// ----------------------------------------------------------------------------
module i2cf_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  logic           shift,
  input  i2cf_pkg::sym_t load_sym,
  input  logic           next_valid,
  input  i2cf_pkg::sym_t next_sym,
  output logic           valid,
  output i2cf_pkg::sym_t sym
);

  logic           valid_r;
  i2cf_pkg::sym_t sym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (shift) begin
      valid_r <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sym_r <= load_sym;
    end else if (shift) begin
      sym_r <= next_sym;
    end
  end

  assign valid = valid_r;
  assign sym   = sym_r;

endmodule

// ===== design/i2cf_cfg.sv =====
// ----------------------------------------------------------------------------
// i2cf_cfg
// Configuration registers: slave address, bit hold and frame hold.
// ----------------------------------------------------------------------------
module i2cf_cfg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  output i2cf_pkg::cfg_t cfg
);

  i2cf_pkg::cfg_t cfg_r;
  i2cf_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (i2cf_pkg::reg_idx_t'(cfg_index))
        i2cf_pkg::REG_SLAVE_ADDR: cfg_nxt.slave_addr = cfg_wdata;
        i2cf_pkg::REG_BIT_HOLD:   cfg_nxt.bit_hold   = cfg_wdata;
        i2cf_pkg::REG_FRAME_HOLD: cfg_nxt.frame_hold = cfg_wdata;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slave_addr <= i2cf_pkg::RST_SLAVE_ADDR;
      cfg_r.bit_hold   <= i2cf_pkg::RST_BIT_HOLD;
      cfg_r.frame_hold <= i2cf_pkg::RST_FRAME_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/i2c_display_byte_framer.sv =====
// ----------------------------------------------------------------------------
// i2c_display_byte_framer
// Frames a display byte as one I2C write transaction of 29 bus symbols.
// ----------------------------------------------------------------------------
// usage:
//   in_*   : one word per byte (payload and command/data flag), valid/ready
//   out_*  : one word per bus symbol, valid/ready, stop symbol marked last
//   cfg_*  : write-only registers 0 address, 1 bit hold, 2 frame hold
// an accepted word is loaded into a row of 29 symbol cells; while the
// receiver accepts, the row shifts one symbol per cycle into an output
// register, so the first symbol passes through the head cell and then the
// output register. the next word is accepted in the cycle the last symbol
// leaves the row, so an unstalled stream runs with no gap between
// transactions. throughput is set by the single output register draining
// the cell row one symbol per cycle while the receiver accepts.
// when the receiver stalls, the output register and a loaded row hold still.
// reset empties the row and output register and loads the register
// defaults (address 0x78, bit hold 2, frame hold 5); a hold of 0 goes out
// as 1.
// ----------------------------------------------------------------------------
module i2c_display_byte_framer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  i2cf_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output i2cf_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);

  i2cf_pkg::cfg_t              cfg;
  i2cf_pkg::frame_t            load_frame;
  i2cf_pkg::frame_t            cell_sym;
  logic [i2cf_pkg::FRAME_LEN-1:0] cell_valid;
  logic                        load;
  logic                        shift;
  logic                        out_valid_r;
  logic                        out_valid_nxt;
  i2cf_pkg::out_word_t         out_data_r;
  i2cf_pkg::out_word_t         out_data_nxt;

  i2cf_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign load_frame = i2cf_pkg::build_frame(cfg.slave_addr, in_data.payload_byte,
                                            in_data.is_data);

  // head symbol moves to the output register
  assign shift    = cell_valid[0] && (!out_valid_r || out_ready);
  assign in_ready = !cell_valid[0] || (!cell_valid[1] && shift);
  assign load     = in_valid && in_ready;

  genvar g;
  generate
    for (g = 0; g < i2cf_pkg::FRAME_LEN; g++) begin : g_cell
      if (g == i2cf_pkg::FRAME_LEN - 1) begin : g_tail
        i2cf_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .load       (load),
          .shift      (shift),
          .load_sym   (load_frame[g]),
          .next_valid (1'b0),
          .next_sym   (load_frame[g]),
          .valid      (cell_valid[g]),
          .sym        (cell_sym[g])
        );
      end else begin : g_body
        i2cf_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .load       (load),
          .shift      (shift),
          .load_sym   (load_frame[g]),
          .next_valid (cell_valid[g+1]),
          .next_sym   (cell_sym[g+1]),
          .valid      (cell_valid[g]),
          .sym        (cell_sym[g])
        );
      end
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (shift) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.symbol_kind = cell_sym[0].kind;
      out_data_nxt.bit_value   = cell_sym[0].bit_value;
      out_data_nxt.hold_units  = (cell_sym[0].kind == i2cf_pkg::SYM_BIT) ?
                                 i2cf_pkg::hold_of(cfg.bit_hold) :
                                 i2cf_pkg::hold_of(cfg.frame_hold);
      out_data_nxt.last_symbol = (cell_sym[0].kind == i2cf_pkg::SYM_STOP);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cell_valid[0] && cell_valid[i2cf_pkg::FRAME_LEN-1] &&
             cell_sym[0].kind == i2cf_pkg::SYM_START)
    else $error("loaded frame does not start with a start symbol");

  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !cell_valid[1])
    else $error("input ready while frame still has symbols to send");

  a_last_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_symbol |-> out_data.symbol_kind == i2cf_pkg::SYM_STOP)
    else $error("last marker on a symbol other than stop");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !load |=> out_valid && $stable(cell_valid))
    else $error("cell row moved while output stalled");

endmodule
